// ----- src/pdf_pkg.sv -----
// Package for the pipelined decode stage with operand forwarding.
// Holds the instruction codes, register numbers, item modes, the
// register-file request struct and the register selection functions.
package pdf_pkg;

    localparam int REG_W      = 4;
    localparam int SLOT_W     = 3;
    localparam int SLOT_COUNT = 5;

    localparam logic [REG_W-1:0] RSP   = 4'd4;
    localparam logic [REG_W-1:0] RNONE = 4'd15;

    localparam logic [3:0] IHALT   = 4'd0;
    localparam logic [3:0] INOP    = 4'd1;
    localparam logic [3:0] IRRMOVQ = 4'd2;
    localparam logic [3:0] IIRMOVQ = 4'd3;
    localparam logic [3:0] IRMMOVQ = 4'd4;
    localparam logic [3:0] IMRMOVQ = 4'd5;
    localparam logic [3:0] IOPQ    = 4'd6;
    localparam logic [3:0] IJXX    = 4'd7;
    localparam logic [3:0] ICALL   = 4'd8;
    localparam logic [3:0] IRET    = 4'd9;
    localparam logic [3:0] IPUSHQ  = 4'd10;
    localparam logic [3:0] IPOPQ   = 4'd11;

    typedef enum logic [1:0] {
        MODE_DECODE = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_SLOT   = 2'd2
    } mode_t;

    // Request from the decode logic to the register file.
    typedef struct packed {
        logic             wr_en;
        logic [REG_W-1:0] wr_addr;
        logic             rd_en;
        logic [REG_W-1:0] rd_addr_a;
        logic [REG_W-1:0] rd_addr_b;
    } rf_req_t;

    function automatic logic [REG_W-1:0] pick_src_a(logic [3:0] ic, logic [REG_W-1:0] ra);
        logic [REG_W-1:0] r;
        r = RNONE;
        if (ic == IRRMOVQ || ic == IRMMOVQ || ic == IOPQ || ic == IPUSHQ)
            r = ra;
        else if (ic == IPOPQ || ic == IRET)
            r = RSP;
        return r;
    endfunction

    function automatic logic [REG_W-1:0] pick_src_b(logic [3:0] ic, logic [REG_W-1:0] rb);
        logic [REG_W-1:0] r;
        r = RNONE;
        if (ic == IOPQ || ic == IRMMOVQ || ic == IMRMOVQ)
            r = rb;
        else if (ic == IPUSHQ || ic == IPOPQ || ic == ICALL || ic == IRET)
            r = RSP;
        return r;
    endfunction

    function automatic logic [REG_W-1:0] pick_dst_e(logic [3:0] ic, logic [REG_W-1:0] rb);
        logic [REG_W-1:0] r;
        r = RNONE;
        if (ic == IRRMOVQ || ic == IIRMOVQ || ic == IOPQ)
            r = rb;
        else if (ic == IPUSHQ || ic == IPOPQ || ic == ICALL || ic == IRET)
            r = RSP;
        return r;
    endfunction

    function automatic logic [REG_W-1:0] pick_dst_m(logic [3:0] ic, logic [REG_W-1:0] ra);
        logic [REG_W-1:0] r;
        r = RNONE;
        if (ic == IMRMOVQ || ic == IPOPQ)
            r = ra;
        return r;
    endfunction

endpackage

// ----- src/pipeline_decode_forwarding.sv -----
// Top level of the pipelined decode stage with operand forwarding.
// Depends on pdf_pkg (codes, struct, select functions) and pdf_regfile.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | in_valid / in_ready  | mode slot dest_reg write_value icode
//            |                      | reg_a reg_b next_pc exec_icode
//            |                      | exec_dst_m exec_cond
//   output   | out_valid / out_ready| src_a src_b dst_e dst_m val_a val_b
//            |                      | bubble_execute
//
// One item per cycle sustained while the output is not stalled; each item
// passes the register-file read stage, then the output register.
// Register-file reads and writes happen at the accept edge, so a later item
// always sees the state an earlier one left; no same-entry overlap exists.
// Reset clears the forwarding slot destinations and the register valid bits
// at once; no clearing pass is needed and the block is ready right away.
// A stalled output holds its result; the read stage still accepts an item
// while the output register is occupied, and in_ready drops only when both
// the read stage and the output register are full and out_ready is low.
module pipeline_decode_forwarding #(
    parameter int REG_COUNT  = 16,
    parameter int WORD_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [2:0]            slot,
    input  logic [3:0]            dest_reg,
    input  logic [WORD_WIDTH-1:0] write_value,
    input  logic [3:0]            icode,
    input  logic [3:0]            reg_a,
    input  logic [3:0]            reg_b,
    input  logic [WORD_WIDTH-1:0] next_pc,
    input  logic [3:0]            exec_icode,
    input  logic [3:0]            exec_dst_m,
    input  logic                  exec_cond,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            src_a,
    output logic [3:0]            src_b,
    output logic [3:0]            dst_e,
    output logic [3:0]            dst_m,
    output logic [WORD_WIDTH-1:0] val_a,
    output logic [WORD_WIDTH-1:0] val_b,
    output logic                  bubble_execute
);

    localparam int RW = pdf_pkg::REG_W;
    localparam int NS = pdf_pkg::SLOT_COUNT;

    // ---------------- handshake ----------------
    logic in_fire;
    logic s1_move;
    logic s1_valid_reg;
    logic out_valid_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    // ---------------- forwarding slots ----------------
    logic [RW-1:0]         fwd_dest_reg  [NS];
    logic [WORD_WIDTH-1:0] fwd_value_reg [NS];
    logic                  slot_load;

    // ---------------- decode of the incoming item ----------------
    logic                  is_decode;
    logic [RW-1:0]         dec_src_a;
    logic [RW-1:0]         dec_src_b;
    logic [RW-1:0]         dec_dst_e;
    logic [RW-1:0]         dec_dst_m;
    logic                  dec_use_valp;
    logic                  dec_bubble;
    logic                  dec_a_hit;
    logic                  dec_b_hit;
    logic [WORD_WIDTH-1:0] dec_a_fwd;
    logic [WORD_WIDTH-1:0] dec_b_fwd;

    always_comb
    begin
        is_decode = 1'b0;
        slot_load = 1'b0;
        unique case (pdf_pkg::mode_t'(mode))
            pdf_pkg::MODE_DECODE: is_decode = 1'b1;
            pdf_pkg::MODE_WRITE:  is_decode = 1'b0;
            pdf_pkg::MODE_SLOT:   slot_load = (slot < 3'(NS));
            default:              is_decode = 1'b0;
        endcase
    end

    // Non-decode items report no registers, zero values and no bubble.
    always_comb
    begin
        dec_src_a    = pdf_pkg::RNONE;
        dec_src_b    = pdf_pkg::RNONE;
        dec_dst_e    = pdf_pkg::RNONE;
        dec_dst_m    = pdf_pkg::RNONE;
        dec_use_valp = 1'b0;
        dec_bubble   = 1'b0;
        if (is_decode)
        begin
            dec_src_a    = pdf_pkg::pick_src_a(icode, reg_a);
            dec_src_b    = pdf_pkg::pick_src_b(icode, reg_b);
            dec_dst_e    = pdf_pkg::pick_dst_e(icode, reg_b);
            dec_dst_m    = pdf_pkg::pick_dst_m(icode, reg_a);
            dec_use_valp = (icode == pdf_pkg::ICALL) || (icode == pdf_pkg::IJXX);
            // Mispredicted jump, or a load whose target this item reads.
            dec_bubble   = ((exec_icode == pdf_pkg::IJXX) && !exec_cond) ||
                           (((exec_icode == pdf_pkg::IMRMOVQ) ||
                             (exec_icode == pdf_pkg::IPOPQ)) &&
                            ((exec_dst_m == dec_src_a) || (exec_dst_m == dec_src_b)));
        end
    end

    // Slot lookup: scan from the highest-numbered slot down so slot 0 wins.
    always_comb
    begin
        dec_a_hit = 1'b0;
        dec_b_hit = 1'b0;
        dec_a_fwd = '0;
        dec_b_fwd = '0;
        for (int k = NS - 1; k >= 0; k--)
        begin
            if (fwd_dest_reg[k] == dec_src_a)
            begin
                dec_a_hit = 1'b1;
                dec_a_fwd = fwd_value_reg[k];
            end
            if (fwd_dest_reg[k] == dec_src_b)
            begin
                dec_b_hit = 1'b1;
                dec_b_fwd = fwd_value_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                fwd_dest_reg[k] <= pdf_pkg::RNONE;
        end
        else if (in_fire && slot_load)
        begin
            fwd_dest_reg[slot] <= dest_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && slot_load)
            fwd_value_reg[slot] <= write_value;
    end

    // ---------------- register file ----------------
    pdf_pkg::rf_req_t      rf_req;
    logic [WORD_WIDTH-1:0] rf_rd_a;
    logic [WORD_WIDTH-1:0] rf_rd_b;

    always_comb
    begin
        rf_req.wr_en     = in_fire && (pdf_pkg::mode_t'(mode) == pdf_pkg::MODE_WRITE) &&
                           (dest_reg != pdf_pkg::RNONE);
        rf_req.wr_addr   = dest_reg;
        rf_req.rd_en     = in_fire && is_decode;
        rf_req.rd_addr_a = dec_src_a;
        rf_req.rd_addr_b = dec_src_b;
    end

    pdf_regfile #(
        .REG_COUNT  (REG_COUNT),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (rf_req),
        .wr_data   (write_value),
        .rd_data_a (rf_rd_a),
        .rd_data_b (rf_rd_b)
    );

    // ---------------- read stage ----------------
    logic [RW-1:0]         s1_src_a_reg;
    logic [RW-1:0]         s1_src_b_reg;
    logic [RW-1:0]         s1_dst_e_reg;
    logic [RW-1:0]         s1_dst_m_reg;
    logic                  s1_use_valp_reg;
    logic                  s1_bubble_reg;
    logic                  s1_a_hit_reg;
    logic                  s1_b_hit_reg;
    logic [WORD_WIDTH-1:0] s1_a_fwd_reg;
    logic [WORD_WIDTH-1:0] s1_b_fwd_reg;
    logic [WORD_WIDTH-1:0] s1_valp_reg;
    logic                  s1_valid_next;

    assign s1_valid_next = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_src_a_reg    <= dec_src_a;
            s1_src_b_reg    <= dec_src_b;
            s1_dst_e_reg    <= dec_dst_e;
            s1_dst_m_reg    <= dec_dst_m;
            s1_use_valp_reg <= dec_use_valp;
            s1_bubble_reg   <= dec_bubble;
            s1_a_hit_reg    <= dec_a_hit;
            s1_b_hit_reg    <= dec_b_hit;
            s1_a_fwd_reg    <= dec_a_fwd;
            s1_b_fwd_reg    <= dec_b_fwd;
            s1_valp_reg     <= next_pc;
        end
    end

    // Select operand: valP (operand A only), then no-register zero, then slot, then file.
    logic [WORD_WIDTH-1:0] s1_val_a;
    logic [WORD_WIDTH-1:0] s1_val_b;

    always_comb
    begin
        priority if (s1_use_valp_reg)
            s1_val_a = s1_valp_reg;
        else if (s1_src_a_reg == pdf_pkg::RNONE)
            s1_val_a = '0;
        else if (s1_a_hit_reg)
            s1_val_a = s1_a_fwd_reg;
        else
            s1_val_a = rf_rd_a;

        priority if (s1_src_b_reg == pdf_pkg::RNONE)
            s1_val_b = '0;
        else if (s1_b_hit_reg)
            s1_val_b = s1_b_fwd_reg;
        else
            s1_val_b = rf_rd_b;
    end

    // ---------------- output register ----------------
    logic                  out_valid_next;
    logic [RW-1:0]         out_src_a_reg;
    logic [RW-1:0]         out_src_b_reg;
    logic [RW-1:0]         out_dst_e_reg;
    logic [RW-1:0]         out_dst_m_reg;
    logic [WORD_WIDTH-1:0] out_val_a_reg;
    logic [WORD_WIDTH-1:0] out_val_b_reg;
    logic                  out_bubble_reg;

    assign out_valid_next = s1_move ? 1'b1 : ((out_valid_reg && out_ready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_src_a_reg  <= s1_src_a_reg;
            out_src_b_reg  <= s1_src_b_reg;
            out_dst_e_reg  <= s1_dst_e_reg;
            out_dst_m_reg  <= s1_dst_m_reg;
            out_val_a_reg  <= s1_val_a;
            out_val_b_reg  <= s1_val_b;
            out_bubble_reg <= s1_bubble_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign src_a          = out_src_a_reg;
    assign src_b          = out_src_b_reg;
    assign dst_e          = out_dst_e_reg;
    assign dst_m          = out_dst_m_reg;
    assign val_a          = out_val_a_reg;
    assign val_b          = out_val_b_reg;
    assign bubble_execute = out_bubble_reg;

    // ---------------- checks ----------------
    a_accept_fills_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted item missing from read stage");

    a_read_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("read stage advanced but output register empty");

    a_val_b_needs_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_val_b_reg != '0)) |-> (out_src_b_reg != pdf_pkg::RNONE))
        else $error("nonzero operand B without a source register");

endmodule

// ----- src/pdf_regfile.sv -----
// Register file of the decode stage: one write port, two read ports,
// registered read data. Depends on pdf_pkg for the request struct.
module pdf_regfile #(
    parameter int REG_COUNT  = 16,
    parameter int WORD_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdf_pkg::rf_req_t      req,
    input  logic [WORD_WIDTH-1:0] wr_data,
    output logic [WORD_WIDTH-1:0] rd_data_a,
    output logic [WORD_WIDTH-1:0] rd_data_b
);

    localparam int IDX_W = $clog2(REG_COUNT);

    logic [WORD_WIDTH-1:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  valid_reg;
    logic [WORD_WIDTH-1:0] rd_a_reg;
    logic [WORD_WIDTH-1:0] rd_b_reg;
    logic                  rd_a_valid_reg;
    logic                  rd_b_valid_reg;

    // Entries never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                valid_reg[req.wr_addr[IDX_W-1:0]] <= 1'b1;
            if (req.rd_en)
            begin
                rd_a_valid_reg <= valid_reg[req.rd_addr_a[IDX_W-1:0]];
                rd_b_valid_reg <= valid_reg[req.rd_addr_b[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            rf_mem[req.wr_addr[IDX_W-1:0]] <= wr_data;
        if (req.rd_en)
        begin
            rd_a_reg <= rf_mem[req.rd_addr_a[IDX_W-1:0]];
            rd_b_reg <= rf_mem[req.rd_addr_b[IDX_W-1:0]];
        end
    end

    assign rd_data_a = rd_a_valid_reg ? rd_a_reg : '0;
    assign rd_data_b = rd_b_valid_reg ? rd_b_reg : '0;

    a_no_wr_rd_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("register file written and read by the same item");

    a_written_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> valid_reg[$past(req.wr_addr[IDX_W-1:0])])
        else $error("written register entry not marked valid");

    a_valid_never_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(valid_reg) & ~valid_reg) == '0)
        else $error("register valid bit cleared outside reset");

endmodule

// ----- tb/sv/decode_forward_checker.sv -----
// Scoreboard for the pipelined decode stage with operand forwarding.
// Watches both handshake channels, predicts each result, compares it.
// Depends on pdf_pkg for register numbers and instruction codes.
module decode_forward_checker #(
    parameter int WORD_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [2:0]            slot,
    input  logic [3:0]            dest_reg,
    input  logic [WORD_WIDTH-1:0] write_value,
    input  logic [3:0]            icode,
    input  logic [3:0]            reg_a,
    input  logic [3:0]            reg_b,
    input  logic [WORD_WIDTH-1:0] next_pc,
    input  logic [3:0]            exec_icode,
    input  logic [3:0]            exec_dst_m,
    input  logic                  exec_cond,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [3:0]            src_a,
    input  logic [3:0]            src_b,
    input  logic [3:0]            dst_e,
    input  logic [3:0]            dst_m,
    input  logic [WORD_WIDTH-1:0] val_a,
    input  logic [WORD_WIDTH-1:0] val_b,
    input  logic                  bubble_execute,
    output int                    pending,
    output int                    failures
);

    typedef struct packed {
        logic [3:0]            sa;
        logic [3:0]            sb;
        logic [3:0]            de;
        logic [3:0]            dm;
        logic [WORD_WIDTH-1:0] va;
        logic [WORD_WIDTH-1:0] vb;
        logic                  bub;
    } decode_res_t;

    logic [WORD_WIDTH-1:0] gpr [16];
    logic [3:0]            fwd_dest [pdf_pkg::SLOT_COUNT];
    logic [WORD_WIDTH-1:0] fwd_val [pdf_pkg::SLOT_COUNT];
    decode_res_t           results_due [$];
    decode_res_t           seen;
    decode_res_t           want;

    // First slot in priority order wins; a source of none reads as zero.
    function automatic logic [WORD_WIDTH-1:0] operand_of(logic [3:0] src);
        if (src == pdf_pkg::RNONE)
            return '0;
        for (int k = 0; k < pdf_pkg::SLOT_COUNT; k++)
            if (fwd_dest[k] == src)
                return fwd_val[k];
        return gpr[src];
    endfunction

    // Apply one accepted item to the shadow state and return its result.
    function automatic decode_res_t next_decode_result();
        decode_res_t r;
        r = '{sa: pdf_pkg::RNONE, sb: pdf_pkg::RNONE, de: pdf_pkg::RNONE,
              dm: pdf_pkg::RNONE, va: '0, vb: '0, bub: 1'b0};
        if (mode != pdf_pkg::MODE_DECODE) begin
            if (mode == pdf_pkg::MODE_WRITE && dest_reg != pdf_pkg::RNONE)
                gpr[dest_reg] = write_value;
            if (mode == pdf_pkg::MODE_SLOT && slot < pdf_pkg::SLOT_COUNT) begin
                fwd_dest[slot] = dest_reg;
                fwd_val[slot]  = write_value;
            end
            return r;
        end
        case (icode)
            pdf_pkg::IRRMOVQ, pdf_pkg::IRMMOVQ, pdf_pkg::IOPQ, pdf_pkg::IPUSHQ:
                r.sa = reg_a;
            pdf_pkg::IPOPQ, pdf_pkg::IRET:
                r.sa = pdf_pkg::RSP;
            default:
                r.sa = pdf_pkg::RNONE;
        endcase
        case (icode)
            pdf_pkg::IOPQ, pdf_pkg::IRMMOVQ, pdf_pkg::IMRMOVQ:
                r.sb = reg_b;
            pdf_pkg::IPUSHQ, pdf_pkg::IPOPQ, pdf_pkg::ICALL, pdf_pkg::IRET:
                r.sb = pdf_pkg::RSP;
            default:
                r.sb = pdf_pkg::RNONE;
        endcase
        case (icode)
            pdf_pkg::IRRMOVQ, pdf_pkg::IIRMOVQ, pdf_pkg::IOPQ:
                r.de = reg_b;
            pdf_pkg::IPUSHQ, pdf_pkg::IPOPQ, pdf_pkg::ICALL, pdf_pkg::IRET:
                r.de = pdf_pkg::RSP;
            default:
                r.de = pdf_pkg::RNONE;
        endcase
        r.dm = (icode == pdf_pkg::IMRMOVQ || icode == pdf_pkg::IPOPQ) ? reg_a : pdf_pkg::RNONE;
        r.va = (icode == pdf_pkg::ICALL || icode == pdf_pkg::IJXX) ? next_pc
                                                                   : operand_of(r.sa);
        r.vb = operand_of(r.sb);
        r.bub = (exec_icode == pdf_pkg::IJXX && !exec_cond) ||
                ((exec_icode == pdf_pkg::IMRMOVQ || exec_icode == pdf_pkg::IPOPQ) &&
                 (exec_dst_m == r.sa || exec_dst_m == r.sb));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                gpr[k] = '0;
            for (int k = 0; k < pdf_pkg::SLOT_COUNT; k++)
            begin
                fwd_dest[k] = pdf_pkg::RNONE;
                fwd_val[k]  = '0;
            end
            results_due.delete();
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {src_a, src_b, dst_e, dst_m, val_a, val_b, bubble_execute};
                if (results_due.size() == 0)
                begin
                    if (failures < 10)
                        $display("decode check: result with nothing outstanding: %h", seen);
                    failures <= failures + 1;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (seen.sa !== want.sa || seen.sb !== want.sb ||
                        seen.de !== want.de || seen.dm !== want.dm ||
                        seen.va !== want.va || seen.vb !== want.vb ||
                        seen.bub !== want.bub)
                    begin
                        if (failures < 10)
                        begin
                            $display("decode check: want src %h %h dst %h %h val %h %h bub %b",
                                     want.sa, want.sb, want.de, want.dm, want.va, want.vb,
                                     want.bub);
                            $display("decode check: got  src %h %h dst %h %h val %h %h bub %b",
                                     seen.sa, seen.sb, seen.de, seen.dm, seen.va, seen.vb,
                                     seen.bub);
                        end
                        failures <= failures + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                results_due.push_back(next_decode_result());
            pending <= results_due.size();
        end
    end

endmodule

// ----- tb/sv/tb_pipeline_decode_forwarding.sv -----
// Testbench top for pipeline_decode_forwarding: clock, reset, stimulus, verdict.
// Depends on pdf_pkg, the block itself and decode_forward_checker.
module tb_pipeline_decode_forwarding;

    localparam int WORD_WIDTH = 64;
    // Mode 3 is not a real operation; the block must answer it and change nothing.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1450;

    typedef struct packed {
        logic [1:0]            mode;
        logic [2:0]            slot;
        logic [3:0]            dest;
        logic [WORD_WIDTH-1:0] wval;
        logic [3:0]            ic;
        logic [3:0]            ra;
        logic [3:0]            rb;
        logic [WORD_WIDTH-1:0] pc;
        logic [3:0]            e_ic;
        logic [3:0]            e_dm;
        logic                  e_c;
    } item_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            mode;
    logic [2:0]            slot;
    logic [3:0]            dest_reg;
    logic [WORD_WIDTH-1:0] write_value;
    logic [3:0]            icode;
    logic [3:0]            reg_a;
    logic [3:0]            reg_b;
    logic [WORD_WIDTH-1:0] next_pc;
    logic [3:0]            exec_icode;
    logic [3:0]            exec_dst_m;
    logic                  exec_cond;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [3:0]            src_a;
    logic [3:0]            src_b;
    logic [3:0]            dst_e;
    logic [3:0]            dst_m;
    logic [WORD_WIDTH-1:0] val_a;
    logic [WORD_WIDTH-1:0] val_b;
    logic                  bubble_execute;
    int                    pending;
    int                    failures;

    // Calm stretch: while set, neither side idles.
    logic                  calm = 1'b0;

    pipeline_decode_forwarding uut (.*);

    decode_forward_checker checker_i (.*);

    always #5 clk = ~clk;

    // Receiver: stall at random about 22 percent of the time, never during the calm stretch.
    always @(posedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);

    // Hard stop in case a handshake hangs or a result never shows up.
    initial
    begin
        #2_000_000;
        $display("tb_pipeline_decode_forwarding: done, errors");
        $finish;
    end

    function automatic logic [WORD_WIDTH-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Favor a few registers so that slots and sources collide often.
    function automatic logic [3:0] hot_reg();
        case ($urandom_range(9))
            0, 1:    return 4'd2;
            2, 3:    return pdf_pkg::RSP;
            4:       return pdf_pkg::RNONE;
            5:       return 4'd9;
            default: return 4'($urandom_range(15));
        endcase
    endfunction

    // Every field random; the builders below pin down the fields that matter.
    function automatic item_t rand_fields();
        item_t it;
        it.mode = 2'($urandom_range(3));
        it.slot = 3'($urandom_range(7));
        it.dest = 4'($urandom_range(15));
        it.wval = rand_word();
        it.ic   = 4'($urandom_range(15));
        it.ra   = 4'($urandom_range(15));
        it.rb   = 4'($urandom_range(15));
        it.pc   = rand_word();
        it.e_ic = 4'($urandom_range(15));
        it.e_dm = 4'($urandom_range(15));
        it.e_c  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic item_t make_write(logic [3:0] dest, logic [WORD_WIDTH-1:0] v);
        item_t it;
        it = rand_fields();
        it.mode = pdf_pkg::MODE_WRITE;
        it.dest = dest;
        it.wval = v;
        return it;
    endfunction

    function automatic item_t make_slot(logic [2:0] s, logic [3:0] dest,
                                        logic [WORD_WIDTH-1:0] v);
        item_t it;
        it = rand_fields();
        it.mode = pdf_pkg::MODE_SLOT;
        it.slot = s;
        it.dest = dest;
        it.wval = v;
        return it;
    endfunction

    function automatic item_t make_decode(logic [3:0] ic, logic [3:0] ra, logic [3:0] rb,
                                          logic [3:0] e_ic, logic [3:0] e_dm, logic e_c);
        item_t it;
        it = rand_fields();
        it.mode = pdf_pkg::MODE_DECODE;
        it.ic   = ic;
        it.ra   = ra;
        it.rb   = rb;
        it.e_ic = e_ic;
        it.e_dm = e_dm;
        it.e_c  = e_c;
        return it;
    endfunction

    // Offer one item and hold it until accepted. Idle first at random,
    // dropping valid only while no item is on offer.
    task automatic send(input item_t it);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= it.mode;
        slot        <= it.slot;
        dest_reg    <= it.dest;
        write_value <= it.wval;
        icode       <= it.ic;
        reg_a       <= it.ra;
        reg_b       <= it.rb;
        next_pc     <= it.pc;
        exec_icode  <= it.e_ic;
        exec_dst_m  <= it.e_dm;
        exec_cond   <= it.e_c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        item_t it;
        int    r;
        int    sent;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= pdf_pkg::MODE_DECODE;
        slot        <= '0;
        dest_reg    <= '0;
        write_value <= '0;
        icode       <= '0;
        reg_a       <= '0;
        reg_b       <= '0;
        next_pc     <= '0;
        exec_icode  <= '0;
        exec_dst_m  <= '0;
        exec_cond   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Decode straight out of reset: everything reads zero.
        send(make_decode(pdf_pkg::IOPQ, 4'd0, 4'd1, pdf_pkg::INOP, pdf_pkg::RNONE, 1'b1));
        // Fill registers with extreme values; a write to none must be dropped.
        send(make_write(4'd0, '1));
        send(make_write(pdf_pkg::RSP, 64'h0123_4567_89ab_cdef));
        send(make_write(pdf_pkg::RNONE, '1));
        // Same destination in two slots: the higher-priority slot must win.
        send(make_slot(3'd4, 4'd2, 64'h5555_5555_5555_5555));
        send(make_slot(3'd0, 4'd2, 64'haaaa_aaaa_aaaa_aaaa));
        // A slot with no destination must never match a source of none.
        send(make_slot(3'd1, pdf_pkg::RNONE, '1));
        // Slot number out of range: ignored.
        send(make_slot(3'd7, 4'd0, '0));
        // Spare mode: answered, no state change.
        it = rand_fields();
        it.mode = MODE_SPARE;
        send(it);
        // Forwarded zero must shadow the stack pointer held in the register file.
        send(make_slot(3'd3, pdf_pkg::RSP, '0));
        // Every opcode, cycling through mispredicted jump, taken jump,
        // load-use on none against none, and load-use on the stack pointer.
        for (int ic = 0; ic < 16; ic++)
        begin
            case (ic % 4)
                0:       send(make_decode(4'(ic), 4'd2, 4'd0, pdf_pkg::IJXX, 4'd3, 1'b0));
                1:       send(make_decode(4'(ic), 4'd2, pdf_pkg::RNONE, pdf_pkg::IJXX,
                                          4'd3, 1'b1));
                2:       send(make_decode(4'(ic), 4'd2, 4'd0, pdf_pkg::IMRMOVQ,
                                          pdf_pkg::RNONE, 1'b1));
                default: send(make_decode(4'(ic), 4'd2, pdf_pkg::RNONE, pdf_pkg::IPOPQ,
                                          pdf_pkg::RSP, 1'b0));
            endcase
        end

        // Random part: decodes as the largest share, against a slot and register file kept
        // busy on a few hot registers, with ignored items mixed in as noise.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (sent >= 500 && sent < 800);
            if (sent == 900)
                drain();
            r = $urandom_range(99);
            if (r < 45)
            begin
                case ($urandom_range(3))
                    0:       it.e_ic = pdf_pkg::IJXX;
                    1:       it.e_ic = pdf_pkg::IMRMOVQ;
                    2:       it.e_ic = pdf_pkg::IPOPQ;
                    default: it.e_ic = 4'($urandom_range(15));
                endcase
                send(make_decode(($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                          : 4'($urandom_range(11)),
                                 hot_reg(), hot_reg(), it.e_ic, hot_reg(),
                                 1'($urandom_range(1))));
                sent++;
            end
            else if (r < 63)
            begin
                send(make_write(hot_reg(), rand_word()));
                sent++;
            end
            else if (r < 90)
            begin
                send(make_slot(3'($urandom_range(4)), hot_reg(), rand_word()));
                sent++;
            end
            else if (r < 95)
            begin
                it = rand_fields();
                it.mode = MODE_SPARE;
                send(it);
                sent++;
            end
            else
            begin
                send(make_slot(3'($urandom_range(7, 5)), hot_reg(), rand_word()));
                sent++;
            end
        end
        calm = 1'b0;

        // Wait out every outstanding result, then wait for strays before the verdict.
        drain();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("tb_pipeline_decode_forwarding: done, clean");
        else
            $display("tb_pipeline_decode_forwarding: done, errors");
        $finish;
    end

endmodule
